FILE: rtl/tcal_pkg.sv
// Shared types and constants for the two-point touch calibration block.
// Depends on nothing; every other file of the block but tcal_queue imports it.

package tcal_pkg;

    // Fixed field widths
    localparam int SCALE_W   = 13;
    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Coordinate codes
    localparam logic [POS_W-1:0] POS_NONE = 16'hFFFF;
    localparam logic [POS_W-1:0] POS_MAX  = 16'h7FFF;

    // Register reset values
    localparam logic [SCALE_W-1:0] WIDTH_RST  = 13'd320;
    localparam logic [SCALE_W-1:0] HEIGHT_RST = 13'd240;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT,
        REG_CAL_I_LOW,
        REG_CAL_J_LOW,
        REG_CAL_I_HIGH,
        REG_CAL_J_HIGH,
        REG_AVERAGE_MODE
    } t_cfg_reg;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEL,
        ST_OUT
    } t_back_state;

    // Group control from the register bank to the back end
    typedef struct packed {
        logic avg_mode;
        logic clear;
    } t_grp_ctl;

endpackage

FILE: rtl/tcal_queue.sv
// Small first-in first-out queue in flip-flops between front and back end.
// Depends on nothing outside this file.

module tcal_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/tcal_front.sv
// Front end: takes one raw sample pair per transfer, forms offsets, spans,
// signs and scaled magnitudes, and hands a job entry to the queue.
// Depends on tcal_pkg.

module tcal_front
    import tcal_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample side
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_touch,
    input  logic [ADC_BITS-1:0]               i_raw_i,
    input  logic [ADC_BITS-1:0]               i_raw_j,
    // calibration
    input  logic [SCALE_W-1:0]                i_scale_x,
    input  logic [SCALE_W-1:0]                i_scale_y,
    input  logic [ADC_BITS-1:0]               i_cal_i_lo,
    input  logic [ADC_BITS-1:0]               i_cal_i_hi,
    input  logic [ADC_BITS-1:0]               i_cal_j_lo,
    input  logic [ADC_BITS-1:0]               i_cal_j_hi,
    // queue side
    output logic                              o_push,
    input  logic                              i_q_ready,
    output logic [2*(SCALE_W+2*ADC_BITS+2):0] o_entry
);

    localparam int PW = SCALE_W + ADC_BITS;

    logic                  r_valid;
    logic                  r_touch;
    logic [ADC_BITS-1:0]   r_raw_i;
    logic [ADC_BITS-1:0]   r_raw_j;
    logic                  accept;
    logic                  taken;

    logic signed [ADC_BITS:0] off_x, off_y, span_x, span_y;
    logic [ADC_BITS-1:0]      offm_x, offm_y, spanm_x, spanm_y;
    logic [PW-1:0]            prod_x, prod_y;
    logic                     neg_x, neg_y, zero_x, zero_y;

    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign taken   = r_valid && i_q_ready;
    assign o_push  = r_valid;

    // Offsets and spans, x from the j axis and y from the i axis
    always_comb begin
        off_x   = $signed({1'b0, r_raw_j}) - $signed({1'b0, i_cal_j_lo});
        off_y   = $signed({1'b0, r_raw_i}) - $signed({1'b0, i_cal_i_lo});
        span_x  = $signed({1'b0, i_cal_j_hi}) - $signed({1'b0, i_cal_j_lo});
        span_y  = $signed({1'b0, i_cal_i_hi}) - $signed({1'b0, i_cal_i_lo});
        offm_x  = off_x[ADC_BITS]  ? ADC_BITS'(-off_x)  : off_x[ADC_BITS-1:0];
        offm_y  = off_y[ADC_BITS]  ? ADC_BITS'(-off_y)  : off_y[ADC_BITS-1:0];
        spanm_x = span_x[ADC_BITS] ? ADC_BITS'(-span_x) : span_x[ADC_BITS-1:0];
        spanm_y = span_y[ADC_BITS] ? ADC_BITS'(-span_y) : span_y[ADC_BITS-1:0];
        neg_x   = off_x[ADC_BITS] ^ span_x[ADC_BITS];
        neg_y   = off_y[ADC_BITS] ^ span_y[ADC_BITS];
        zero_x  = (spanm_x == '0);
        zero_y  = (spanm_y == '0);
        prod_x  = PW'(i_scale_x) * PW'(offm_x);
        prod_y  = PW'(i_scale_y) * PW'(offm_y);
    end

    // Pack: touch, then per axis {neg, zero, span magnitude, product magnitude}
    assign o_entry = {r_touch,
                      neg_x, zero_x, spanm_x, prod_x,
                      neg_y, zero_y, spanm_y, prod_y};

    // Hold the sample until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_touch <= i_touch;
            r_raw_i <= i_raw_i;
            r_raw_j <= i_raw_j;
        end
    end

endmodule

FILE: rtl/tcal_back.sv
// Back end: bit-serial signed division for both axes, best-two-of-three
// selection and averaging in average mode, and the result register.
// Depends on tcal_pkg.

module tcal_back
    import tcal_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_grp_ctl                          i_ctl,
    // queue side
    input  logic                              i_valid,
    input  logic [2*(SCALE_W+2*ADC_BITS+2):0] i_entry,
    output logic                              o_pop,
    // result side
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [POS_W-1:0]                  o_pos_x,
    output logic [POS_W-1:0]                  o_pos_y,
    output logic                              o_div_error
);

    localparam int PW  = SCALE_W + ADC_BITS;
    localparam int AXW = PW + ADC_BITS + 2;
    localparam int EW  = 2 * AXW + 1;
    localparam int CW  = $clog2(PW + 1);

    t_back_state r_state, n_state;

    logic [AXW-1:0]      r_ax_x, n_ax_x, r_ax_y, n_ax_y;
    logic [ADC_BITS-1:0] r_rem, n_rem;
    logic [PW-1:0]       r_quo, n_quo;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_axis, n_axis;
    logic [POS_W-1:0]    r_px, n_px, r_py, n_py;
    logic                r_err, n_err;
    logic [POS_W-1:0]    r_held_x [2];
    logic [POS_W-1:0]    r_held_y [2];
    logic [POS_W-1:0]    n_held_x [2];
    logic [POS_W-1:0]    n_held_y [2];
    logic [1:0]          r_count, n_count;
    logic                r_held_err, n_held_err;
    logic [POS_W-1:0]    r_ax_a, n_ax_a, r_ax_b, n_ax_b;
    logic [POS_W-1:0]    r_ay_a, n_ay_a, r_ay_b, n_ay_b;
    logic                r_oerr, n_oerr;
    logic                r_out_valid, n_out_valid;
    logic [POS_W-1:0]    r_out_x, n_out_x, r_out_y, n_out_y;
    logic                r_out_err, n_out_err;

    logic [AXW-1:0]      cur;
    logic [ADC_BITS-1:0] dmag;
    logic [ADC_BITS:0]   trial;
    logic [ADC_BITS:0]   diff;
    logic                ge;
    logic                div_done;
    logic [POS_W-1:0]    q_low;
    logic [POS_W-1:0]    q_sgn;
    logic [POS_W-1:0]    res;
    logic                out_free;
    logic [2*POS_W-1:0]  pair_x, pair_y;
    logic [POS_W:0]      sum_x, sum_y;

    // Exact distance of two 16-bit signed values
    function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] q);
        logic signed [POS_W:0] d;
        d = $signed({p[POS_W-1], p}) - $signed({q[POS_W-1], q});
        return d[POS_W] ? (POS_W+1)'(-d) : d;
    endfunction

    // Closest pair of three, ties to the earlier pair
    function automatic logic [2*POS_W-1:0] pick_pair(input logic [POS_W-1:0] p,
                                                     input logic [POS_W-1:0] q,
                                                     input logic [POS_W-1:0] r);
        logic [POS_W:0] dpq, dpr, dqr;
        dpq = abs_diff(p, q);
        dpr = abs_diff(p, r);
        dqr = abs_diff(q, r);
        if (dpq <= dpr && dpq <= dqr) begin
            return {p, q};
        end else if (dpr <= dpq && dpr <= dqr) begin
            return {p, r};
        end
        return {q, r};
    endfunction

    // Divider step on the current axis
    assign cur      = r_axis ? r_ax_y : r_ax_x;
    assign dmag     = cur[PW+ADC_BITS-1:PW];
    assign trial    = {r_rem, r_quo[PW-1]};
    assign ge       = (trial >= {1'b0, dmag});
    assign diff     = trial - {1'b0, dmag};
    assign div_done = (r_cnt == CW'(PW));

    // Apply sign, keep low bits, clamp negatives and zero spans to 0
    assign q_low = r_quo[POS_W-1:0];
    assign q_sgn = cur[PW+ADC_BITS+1] ? (~q_low + 1'b1) : q_low;
    assign res   = (cur[PW+ADC_BITS] || q_sgn > POS_MAX) ? '0 : q_sgn;

    assign out_free = !r_out_valid || i_ready;
    assign pair_x   = pick_pair(r_held_x[0], r_held_x[1], r_px);
    assign pair_y   = pick_pair(r_held_y[0], r_held_y[1], r_py);
    assign sum_x    = $signed({r_ax_a[POS_W-1], r_ax_a}) + $signed({r_ax_b[POS_W-1], r_ax_b});
    assign sum_y    = $signed({r_ay_a[POS_W-1], r_ay_a}) + $signed({r_ay_b[POS_W-1], r_ay_b});

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_entry[EW-1] ? ST_DIV : ST_SEL;
                end
            end
            ST_DIV: begin
                if (div_done && r_axis) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                if (i_ctl.avg_mode && r_count < 2'd2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        o_pop       = 1'b0;
        n_ax_x      = r_ax_x;
        n_ax_y      = r_ax_y;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_px        = r_px;
        n_py        = r_py;
        n_err       = r_err;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_count     = r_count;
        n_held_err  = r_held_err;
        n_ax_a      = r_ax_a;
        n_ax_b      = r_ax_b;
        n_ay_a      = r_ay_a;
        n_ay_b      = r_ay_b;
        n_oerr      = r_oerr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_err   = r_out_err;
        case (r_state)
            ST_IDLE: begin
                o_pop  = i_valid;
                n_ax_x = i_entry[2*AXW-1:AXW];
                n_ax_y = i_entry[AXW-1:0];
                n_rem  = '0;
                n_quo  = i_entry[AXW+PW-1:AXW];
                n_cnt  = '0;
                n_axis = 1'b0;
                n_px   = POS_NONE;
                n_py   = POS_NONE;
                n_err  = i_entry[EW-1] && (i_entry[AXW+PW+ADC_BITS] || i_entry[PW+ADC_BITS]);
            end
            ST_DIV: begin
                if (div_done) begin
                    // Store this axis, start the next
                    if (r_axis) begin
                        n_py = res;
                    end else begin
                        n_px   = res;
                        n_rem  = '0;
                        n_quo  = r_ax_y[PW-1:0];
                        n_cnt  = '0;
                        n_axis = 1'b1;
                    end
                end else begin
                    n_rem = ge ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
                    n_quo = {r_quo[PW-2:0], ge};
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SEL: begin
                if (!i_ctl.avg_mode) begin
                    n_ax_a  = r_px;
                    n_ax_b  = r_px;
                    n_ay_a  = r_py;
                    n_ay_b  = r_py;
                    n_oerr  = r_err;
                    n_count = '0;
                end else if (r_count < 2'd2) begin
                    // Hold the position for the group
                    n_held_x[r_count[0]] = r_px;
                    n_held_y[r_count[0]] = r_py;
                    n_held_err           = r_held_err | r_err;
                    n_count              = r_count + 1'b1;
                end else begin
                    n_ax_a     = pair_x[2*POS_W-1:POS_W];
                    n_ax_b     = pair_x[POS_W-1:0];
                    n_ay_a     = pair_y[2*POS_W-1:POS_W];
                    n_ay_b     = pair_y[POS_W-1:0];
                    n_oerr     = r_held_err | r_err;
                    n_count    = '0;
                    n_held_err = 1'b0;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = sum_x[POS_W:1];
                    n_out_y     = sum_y[POS_W:1];
                    n_out_err   = r_oerr;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
        // Drop a partial group on a mode write
        if (i_ctl.clear) begin
            n_count    = '0;
            n_held_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_held_err  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_held_err  <= n_held_err;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax_x    <= n_ax_x;
        r_ax_y    <= n_ax_y;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_px      <= n_px;
        r_py      <= n_py;
        r_err     <= n_err;
        r_held_x  <= n_held_x;
        r_held_y  <= n_held_y;
        r_ax_a    <= n_ax_a;
        r_ax_b    <= n_ax_b;
        r_ay_a    <= n_ay_a;
        r_ay_b    <= n_ay_b;
        r_oerr    <= n_oerr;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_err <= n_out_err;
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_div_error = r_out_err;

endmodule

FILE: rtl/touch_calibrate_best_two_avg.sv
// Top level of the two-point touch calibration block: register bank, front
// end, job queue and back end. Depends on tcal_pkg, tcal_front, tcal_queue, tcal_back.
//
// Channel   | Direction | Payload
// s (tdata) | in        | tdata: raw_i, raw_j ; tuser: touching
// m (tdata) | out       | tdata: pos_x, pos_y ; tuser: div_error
// cfg       | in        | write enable, register index, write data
//
// Flow: a touched sample runs the shared bit-serial divider in the back end
// once per axis; an untouched sample skips the division. The front end takes a
// sample each cycle while the two-entry queue has room.
// Reset: synchronous, active low; registers return to their reset values and
// no pass over any store is needed.
// Stalls: a held result stalls the back end; the queue keeps the front open until it fills.

module touch_calibrate_best_two_avg
    import tcal_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [((2*ADC_BITS+7)/8)*8-1:0] i_s_tdata,  // raw_i, raw_j, zero fill
    input  logic [0:0]                  i_s_tuser,      // touching
    // position stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [2*POS_W-1:0]          o_m_tdata,      // pos_x, pos_y
    output logic [0:0]                  o_m_tuser,      // div_error
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [((ADC_BITS > SCALE_W) ? ADC_BITS : SCALE_W)-1:0] i_cfg_data
);

    localparam int EW = 2 * (SCALE_W + 2 * ADC_BITS + 2) + 1;

    logic [SCALE_W-1:0]  r_width;
    logic [SCALE_W-1:0]  r_height;
    logic [ADC_BITS-1:0] r_cal_i_lo, r_cal_j_lo, r_cal_i_hi, r_cal_j_hi;
    logic                r_avg;
    t_grp_ctl            grp_ctl;

    logic                f_push;
    logic [EW-1:0]       f_entry;
    logic                q_ready;
    logic                q_valid;
    logic [EW-1:0]       q_entry;
    logic                q_pop;
    logic [POS_W-1:0]    pos_x, pos_y;
    logic                div_error;

    // Register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
            r_cal_i_lo <= '0;
            r_cal_j_lo <= '0;
            r_cal_i_hi <= '1;
            r_cal_j_hi <= '1;
            r_avg      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_SCREEN_WIDTH:  r_width    <= i_cfg_data[SCALE_W-1:0];
                REG_SCREEN_HEIGHT: r_height   <= i_cfg_data[SCALE_W-1:0];
                REG_CAL_I_LOW:     r_cal_i_lo <= i_cfg_data[ADC_BITS-1:0];
                REG_CAL_J_LOW:     r_cal_j_lo <= i_cfg_data[ADC_BITS-1:0];
                REG_CAL_I_HIGH:    r_cal_i_hi <= i_cfg_data[ADC_BITS-1:0];
                REG_CAL_J_HIGH:    r_cal_j_hi <= i_cfg_data[ADC_BITS-1:0];
                REG_AVERAGE_MODE:  r_avg      <= i_cfg_data[0];
                default:           r_avg      <= r_avg;
            endcase
        end
    end

    assign grp_ctl.avg_mode = r_avg;
    assign grp_ctl.clear    = i_cfg_we && (i_cfg_addr == REG_AVERAGE_MODE);

    tcal_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_touch    (i_s_tuser[0]),
        .i_raw_i    (i_s_tdata[ADC_BITS-1:0]),
        .i_raw_j    (i_s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_scale_x  (r_width),
        .i_scale_y  (r_height),
        .i_cal_i_lo (r_cal_i_lo),
        .i_cal_i_hi (r_cal_i_hi),
        .i_cal_j_lo (r_cal_j_lo),
        .i_cal_j_hi (r_cal_j_hi),
        .o_push     (f_push),
        .i_q_ready  (q_ready),
        .o_entry    (f_entry)
    );

    tcal_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .i_pop   (q_pop)
    );

    tcal_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (grp_ctl),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_pop       (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_pos_x     (pos_x),
        .o_pos_y     (pos_y),
        .o_div_error (div_error)
    );

    assign o_m_tdata    = {pos_y, pos_x};
    assign o_m_tuser[0] = div_error;

    // Back end takes only entries that are there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    // Front end stalls only when it holds a sample the queue refuses
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (f_push && !q_ready))
        else $error("front end stalled without cause");

    // No result straight after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule
